@@ hdl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, field widths, codes and helpers of the pairwise concordance
// pattern counter.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // default sizes
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIMS   = 7;

    // field widths
    localparam int OP_W       = 2;
    localparam int PT_IDX_W   = 10;
    localparam int DIM_IDX_W  = 3;
    localparam int COORD_W    = 32;
    localparam int PAT_IDX_W  = 6;
    localparam int COUNT_W    = 10;
    localparam int POINTS_W   = 11;
    localparam int DIMS_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 1'd1;

    // top level control
    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_SWEEP,
        T_ACK
    } t_top_state;

    // pair sweep sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD_I,
        S_LOAD_J,
        S_BUMP_I,
        S_BUMP_IJ,
        S_BUMP_J,
        S_DONE
    } t_swp_state;

    // sweep engine status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_swp_stat;

    // dimension count in effect: zero acts as one, large values saturate
    function automatic logic [DIMS_W-1:0] eff_dims(input logic [DIMS_W-1:0] dims,
                                                   input int max_dims);
        if (dims == '0)
            return DIMS_W'(1);
        if (32'(dims) > max_dims)
            return DIMS_W'(max_dims);
        return dims;
    endfunction

endpackage

@@ hdl/pcc_ram.sv @@
// ----------------------------------------------------------------------------
// pcc_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module pcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pcc_sweep.sv @@
// ----------------------------------------------------------------------------
// pcc_sweep
// Pair sweep engine: clears the pattern count memory, then walks every
// pair i < j, builds the concordance pattern from the coordinate memory and
// bumps the saturating count of both points by read-modify-write.
// ----------------------------------------------------------------------------
module pcc_sweep
    import pcc_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_DIMS   = DEF_MAX_DIMS
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_start,
    input  logic [POINTS_W-1:0]                                 i_points,
    input  logic [DIMS_W-1:0]                                   i_dims,
    output logic                                                o_co_re,
    output logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]              o_co_raddr,
    input  logic [COORD_W-1:0]                                  i_co_rdata,
    output logic                                                o_ct_we,
    output logic [$clog2(MAX_POINTS*(2**(MAX_DIMS-1)))-1:0]     o_ct_waddr,
    output logic [COUNT_W-1:0]                                  o_ct_wdata,
    output logic                                                o_ct_re,
    output logic [$clog2(MAX_POINTS*(2**(MAX_DIMS-1)))-1:0]     o_ct_raddr,
    input  logic [COUNT_W-1:0]                                  i_ct_rdata,
    output t_swp_stat                                           o_stat
);

    localparam int PT_W      = $clog2(MAX_POINTS);
    localparam int PC_W      = $clog2(MAX_POINTS + 1);
    localparam int PAT_BITS  = MAX_DIMS - 1;
    localparam int CNT_DEPTH = MAX_POINTS * (2 ** PAT_BITS);
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int CO_AW     = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int DIX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    t_swp_state           r_state, n_state;
    logic [CNT_AW-1:0]    r_clr_addr, n_clr_addr;
    logic                 r_after_clr, n_after_clr;
    logic [PC_W-1:0]      r_i, n_i;
    logic [PC_W-1:0]      r_j, n_j;
    logic [DIMS_W-1:0]    r_dim, n_dim;
    logic                 r_below, n_below;
    logic [PAT_IDX_W-1:0] r_pat, n_pat;
    logic [COORD_W-1:0]   r_coord_i [MAX_DIMS];

    logic [PC_W-1:0]      pts_eff;
    logic [DIMS_W-1:0]    dims_eff;
    logic [DIMS_W-1:0]    dix;
    logic signed [COORD_W-1:0] ci;
    logic signed [COORD_W-1:0] cj;
    logic                 hit;
    logic                 ci_we;

    // coordinate memory address of one point and dimension
    function automatic logic [CO_AW-1:0] f_co_addr(input logic [PC_W-1:0] pt,
                                                  input logic [DIMS_W-1:0] dim);
        return CO_AW'(pt[PT_W-1:0]) * CO_AW'(MAX_DIMS) + CO_AW'(dim);
    endfunction

    // count memory address of one point and pattern
    function automatic logic [CNT_AW-1:0] f_ct_addr(input logic [PC_W-1:0] pt,
                                                   input logic [PAT_IDX_W-1:0] pat);
        return (CNT_AW'(pt[PT_W-1:0]) << PAT_BITS) | CNT_AW'(pat);
    endfunction

    // saturating increment
    function automatic logic [COUNT_W-1:0] f_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    // effective sweep size
    always_comb begin
        if (32'(i_points) > MAX_POINTS)
            pts_eff = PC_W'(MAX_POINTS);
        else
            pts_eff = PC_W'(i_points);
        dims_eff = eff_dims(i_dims, MAX_DIMS);
    end

    // coordinate returning from memory belongs to the dimension issued last cycle
    assign dix = r_dim - DIMS_W'(1);
    assign ci  = $signed(r_coord_i[dix[DIX_W-1:0]]);
    assign cj  = $signed(i_co_rdata);
    assign hit = r_below ? (ci < cj) : (ci > cj);

    // next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_after_clr = r_after_clr;
        n_i         = r_i;
        n_j         = r_j;
        n_dim       = r_dim;
        n_below     = r_below;
        n_pat       = r_pat;
        ci_we       = 1'b0;
        o_co_re     = 1'b0;
        o_co_raddr  = f_co_addr(r_i, r_dim);
        o_ct_we     = 1'b0;
        o_ct_waddr  = f_ct_addr(r_i, r_pat);
        o_ct_wdata  = f_inc(i_ct_rdata);
        o_ct_re     = 1'b0;
        o_ct_raddr  = f_ct_addr(r_i, r_pat);
        o_stat.busy = (r_state != S_IDLE);
        o_stat.done = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_clr_addr  = '0;
                    n_after_clr = 1'b1;
                    n_state     = S_CLEAR;
                end
            end

            // one count entry zeroed per cycle
            S_CLEAR: begin
                o_ct_we    = 1'b1;
                o_ct_waddr = r_clr_addr;
                o_ct_wdata = '0;
                if (r_clr_addr == CNT_AW'(CNT_DEPTH - 1)) begin
                    if (!r_after_clr) begin
                        n_state = S_IDLE;
                    end else if (pts_eff < PC_W'(2)) begin
                        n_state = S_DONE;
                    end else begin
                        n_i     = '0;
                        n_dim   = '0;
                        n_state = S_LOAD_I;
                    end
                end else begin
                    n_clr_addr = r_clr_addr + CNT_AW'(1);
                end
            end

            // fetch the coordinates of point i into registers
            S_LOAD_I: begin
                o_co_re    = (r_dim < dims_eff);
                o_co_raddr = f_co_addr(r_i, r_dim);
                ci_we      = (r_dim != '0);
                if (r_dim == dims_eff) begin
                    n_j     = r_i + PC_W'(1);
                    n_dim   = '0;
                    n_pat   = '0;
                    n_state = S_LOAD_J;
                end else begin
                    n_dim = r_dim + DIMS_W'(1);
                end
            end

            // stream the coordinates of point j and build the pattern
            S_LOAD_J: begin
                o_co_re    = (r_dim < dims_eff);
                o_co_raddr = f_co_addr(r_j, r_dim);
                if (r_dim != '0) begin
                    if (dix == '0)
                        n_below = ($signed(r_coord_i[0]) < cj);
                    else
                        n_pat = r_pat | (PAT_IDX_W'(hit) << (dix - DIMS_W'(1)));
                end
                if (r_dim == dims_eff)
                    n_state = S_BUMP_I;
                else
                    n_dim = r_dim + DIMS_W'(1);
            end

            // read count of point i
            S_BUMP_I: begin
                o_ct_re    = 1'b1;
                o_ct_raddr = f_ct_addr(r_i, r_pat);
                n_state    = S_BUMP_IJ;
            end

            // write back point i, read count of point j
            S_BUMP_IJ: begin
                o_ct_we    = 1'b1;
                o_ct_waddr = f_ct_addr(r_i, r_pat);
                o_ct_re    = 1'b1;
                o_ct_raddr = f_ct_addr(r_j, r_pat);
                n_state    = S_BUMP_J;
            end

            // write back point j and step to the next pair
            S_BUMP_J: begin
                o_ct_we    = 1'b1;
                o_ct_waddr = f_ct_addr(r_j, r_pat);
                n_dim      = '0;
                n_pat      = '0;
                if (r_j + PC_W'(1) < pts_eff) begin
                    n_j     = r_j + PC_W'(1);
                    n_state = S_LOAD_J;
                end else if (r_i + PC_W'(2) < pts_eff) begin
                    n_i     = r_i + PC_W'(1);
                    n_state = S_LOAD_I;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                o_stat.done = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers; reset starts a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_after_clr <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_after_clr <= n_after_clr;
        end
    end

    // sweep indexes and pattern build
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_dim   <= n_dim;
        r_below <= n_below;
        r_pat   <= n_pat;
        if (ci_we)
            r_coord_i[dix[DIX_W-1:0]] <= i_co_rdata;
    end

endmodule

@@ hdl/pairwise_concordance_pattern_counter_core.sv @@
// ----------------------------------------------------------------------------
// pairwise_concordance_pattern_counter_core
// Multivariate concordance pattern counter over a loaded point set, with
// request decode, configuration registers, count readout and output stage.
// ----------------------------------------------------------------------------
// Points are loaded one coordinate per request (op 0) into a coordinate RAM
// of MAX_POINTS x MAX_DIMS words. A compute request (op 1) first zeroes the
// pattern count RAM, one entry per cycle (MAX_POINTS * 2^(MAX_DIMS-1)
// entries, 65536 at the defaults), then walks every pair i < j: point i's
// coordinates are fetched once per i, and each pair streams point j's
// coordinates and then read-modify-writes both counts in the count RAM;
// one done result follows. A read request (op 2) returns the 2^(d-1)
// counts of one point, where d is the effective dims_in_use, at one result
// per cycle while the result side accepts them. After reset the block runs
// the same clearing pass and accepts no request until it has finished;
// configuration writes are taken at any time and must only change while
// the block is idle.
module pairwise_concordance_pattern_counter_core
    import pcc_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_DIMS   = DEF_MAX_DIMS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [OP_W-1:0]             i_op,
    input  logic [PT_IDX_W-1:0]         i_point_index,
    input  logic [DIM_IDX_W-1:0]        i_dim_index,
    input  logic signed [COORD_W-1:0]   i_coord_value,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [PAT_IDX_W-1:0]        o_pattern_index,
    output logic [COUNT_W-1:0]          o_pattern_count,
    output logic                        o_is_last,
    output logic                        o_is_done_ack
);

    localparam int PT_W      = $clog2(MAX_POINTS);
    localparam int PAT_BITS  = MAX_DIMS - 1;
    localparam int CNT_DEPTH = MAX_POINTS * (2 ** PAT_BITS);
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int CO_DEPTH  = MAX_POINTS * MAX_DIMS;
    localparam int CO_AW     = $clog2(CO_DEPTH);

    t_top_state           r_state, n_state;
    logic [POINTS_W-1:0]  r_points;
    logic [DIMS_W-1:0]    r_dims;
    logic [PT_IDX_W-1:0]  r_rd_pt, n_rd_pt;
    logic                 r_rd_zero, n_rd_zero;
    logic [PAT_IDX_W-1:0] r_p, n_p;
    logic [PAT_IDX_W-1:0] r_m_last, n_m_last;
    logic                 r_rd_pend, n_rd_pend;
    logic [PAT_IDX_W-1:0] r_pend_pat, n_pend_pat;
    logic                 r_pend_last, n_pend_last;
    logic                 r_pend_zero, n_pend_zero;
    logic                 r_out_valid, n_out_valid;
    logic [PAT_IDX_W-1:0] r_out_pat, n_out_pat;
    logic [COUNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ack, n_out_ack;

    logic                 accept;
    logic                 out_free;
    logic                 move;
    logic                 issue;
    logic                 swp_start;
    logic [DIMS_W-1:0]    dims_eff;
    t_swp_stat            swp_stat;

    logic                 co_we;
    logic [CO_AW-1:0]     co_waddr;
    logic                 co_re;
    logic [CO_AW-1:0]     co_raddr;
    logic [COORD_W-1:0]   co_rdata;

    logic                 ct_we;
    logic [CNT_AW-1:0]    ct_waddr;
    logic [COUNT_W-1:0]   ct_wdata;
    logic                 ct_re;
    logic [CNT_AW-1:0]    ct_raddr;
    logic [COUNT_W-1:0]   ct_rdata;
    logic                 swp_ct_re;
    logic [CNT_AW-1:0]    swp_ct_raddr;

    // request handshake
    assign o_in_ready = (r_state == T_IDLE) && !swp_stat.busy && !r_rd_pend;
    assign accept     = i_in_valid && o_in_ready;
    assign dims_eff   = eff_dims(r_dims, MAX_DIMS);

    // coordinate load, out of range requests are dropped
    assign co_we    = accept && (i_op == OP_LOAD)
                   && (32'(i_point_index) < MAX_POINTS)
                   && (32'(i_dim_index) < MAX_DIMS);
    assign co_waddr = CO_AW'(PT_W'(i_point_index)) * CO_AW'(MAX_DIMS)
                    + CO_AW'(i_dim_index);

    // readout pipeline: RAM data register, then output register
    assign out_free = !r_out_valid || i_out_ready;
    assign move     = r_rd_pend && out_free;
    assign issue    = (r_state == T_READ) && (!r_rd_pend || move);

    // count RAM read port shared between sweep and readout
    assign ct_re    = swp_stat.busy ? swp_ct_re : issue;
    assign ct_raddr = swp_stat.busy ? swp_ct_raddr
                                    : ((CNT_AW'(PT_W'(r_rd_pt)) << PAT_BITS) | CNT_AW'(r_p));

    // request decode, readout sequencing and output stage
    always_comb begin
        n_state     = r_state;
        n_rd_pt     = r_rd_pt;
        n_rd_zero   = r_rd_zero;
        n_p         = r_p;
        n_m_last    = r_m_last;
        n_rd_pend   = r_rd_pend;
        n_pend_pat  = r_pend_pat;
        n_pend_last = r_pend_last;
        n_pend_zero = r_pend_zero;
        n_out_valid = r_out_valid;
        n_out_pat   = r_out_pat;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        n_out_ack   = r_out_ack;
        swp_start   = 1'b0;

        // output register drains
        if (i_out_ready)
            n_out_valid = 1'b0;

        // pending count moves into the output register
        if (move) begin
            n_rd_pend   = 1'b0;
            n_out_valid = 1'b1;
            n_out_pat   = r_pend_pat;
            n_out_cnt   = r_pend_zero ? '0 : ct_rdata;
            n_out_last  = r_pend_last;
            n_out_ack   = 1'b0;
        end

        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_SWEEP: begin
                            swp_start = 1'b1;
                            n_state   = T_SWEEP;
                        end
                        OP_READ: begin
                            n_rd_pt   = i_point_index;
                            n_rd_zero = (32'(i_point_index) >= MAX_POINTS);
                            n_p       = '0;
                            n_m_last  = PAT_IDX_W'((7'd1 << (dims_eff - DIMS_W'(1))) - 7'd1);
                            n_state   = T_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one count read per cycle while the pipeline has room
            T_READ: begin
                if (issue) begin
                    n_rd_pend   = 1'b1;
                    n_pend_pat  = r_p;
                    n_pend_last = (r_p == r_m_last);
                    n_pend_zero = r_rd_zero;
                    if (r_p == r_m_last)
                        n_state = T_IDLE;
                    else
                        n_p = r_p + PAT_IDX_W'(1);
                end
            end

            T_SWEEP: begin
                if (swp_stat.done)
                    n_state = T_ACK;
            end

            // sweep finished result
            T_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pat   = '0;
                    n_out_cnt   = '0;
                    n_out_last  = 1'b1;
                    n_out_ack   = 1'b1;
                    n_state     = T_IDLE;
                end
            end

            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_points    <= POINTS_W'(2);
            r_dims      <= DIMS_W'(2);
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POINTS: r_points <= i_cfg_wdata[POINTS_W-1:0];
                    REG_DIMS:   r_dims   <= i_cfg_wdata[DIMS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_pt     <= n_rd_pt;
        r_rd_zero   <= n_rd_zero;
        r_p         <= n_p;
        r_m_last    <= n_m_last;
        r_pend_pat  <= n_pend_pat;
        r_pend_last <= n_pend_last;
        r_pend_zero <= n_pend_zero;
        r_out_pat   <= n_out_pat;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
        r_out_ack   <= n_out_ack;
    end

    assign o_out_valid     = r_out_valid;
    assign o_pattern_index = r_out_pat;
    assign o_pattern_count = r_out_cnt;
    assign o_is_last       = r_out_last;
    assign o_is_done_ack   = r_out_ack;

    // coordinate store
    pcc_ram #(
        .WIDTH (COORD_W),
        .DEPTH (CO_DEPTH)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (co_we),
        .i_waddr (co_waddr),
        .i_wdata (i_coord_value),
        .i_re    (co_re),
        .i_raddr (co_raddr),
        .o_rdata (co_rdata)
    );

    // pattern count store
    pcc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_re    (ct_re),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    // pair sweep engine
    pcc_sweep #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (swp_start),
        .i_points   (r_points),
        .i_dims     (r_dims),
        .o_co_re    (co_re),
        .o_co_raddr (co_raddr),
        .i_co_rdata (co_rdata),
        .o_ct_we    (ct_we),
        .o_ct_waddr (ct_waddr),
        .o_ct_wdata (ct_wdata),
        .o_ct_re    (swp_ct_re),
        .o_ct_raddr (swp_ct_raddr),
        .i_ct_rdata (ct_rdata),
        .o_stat     (swp_stat)
    );

endmodule

@@ bench/pairwise_concordance_pattern_counter_core_tb.sv @@
// ----------------------------------------------------------------------------
// pairwise_concordance_pattern_counter_core_tb
// Self-checking bench for the concordance pattern counter. It loads point
// sets, runs pair sweeps and reads back the counts of chosen points, and predicts
// each result from its own copy of the coordinates, counts and registers.
// Both handshakes idle at random, and the result side holds off once for a
// long stretch so that the block backs up into its request side.
// ----------------------------------------------------------------------------
module pairwise_concordance_pattern_counter_core_tb
    import pcc_pkg::*;
();

    localparam int MAX_PTS   = DEF_MAX_POINTS;
    localparam int MAX_DIM   = DEF_MAX_DIMS;
    localparam int PAT_SLOTS = 1 << (MAX_DIM - 1);

    localparam int GAP_MAX         = 18;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 280;
    localparam int MAX_ROUNDS      = 8;
    // every sweep and the reset start with a clearing pass over the whole count
    // memory; the limit leaves room for about a dozen of them, 64-result reads
    // under the longest stalls and the long hold-off
    localparam int CYCLE_LIMIT     = 5_000_000;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [DIM_IDX_W-1:0] DIM_BEYOND  = DIM_IDX_W'(MAX_DIM);
    localparam logic signed [COORD_W-1:0] COORD_MAXV = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MINV = 32'sh8000_0000;

    typedef struct packed {
        logic [PAT_IDX_W-1:0] pattern_index;
        logic [COUNT_W-1:0]   pattern_count;
        logic                 is_last;
        logic                 is_done_ack;
    } t_count_result;

    // block ports
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata   = '0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_op          = '0;
    logic [PT_IDX_W-1:0]       i_point_index = '0;
    logic [DIM_IDX_W-1:0]      i_dim_index   = '0;
    logic signed [COORD_W-1:0] i_coord_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready   = 1'b0;
    logic [PAT_IDX_W-1:0]      o_pattern_index;
    logic [COUNT_W-1:0]        o_pattern_count;
    logic                      o_is_last;
    logic                      o_is_done_ack;

    // predictor state
    logic signed [COORD_W-1:0] coord_mem [MAX_PTS][MAX_DIM];
    bit                        coord_set [MAX_PTS][MAX_DIM];
    logic [COUNT_W-1:0]        tally [MAX_PTS][PAT_SLOTS];
    logic [POINTS_W-1:0]       cfg_points = POINTS_W'(2);
    logic [DIMS_W-1:0]         cfg_dims   = DIMS_W'(2);
    t_count_result             expected_q [$];

    // run control and tallies
    bit send_gaps    = 1'b1;
    bit sink_stalls  = 1'b1;
    int holds_asked  = 0;
    int holds_taken  = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int loads_taken  = 0;
    int sweeps_taken = 0;
    int reads_taken  = 0;
    int results_checked = 0;

    pairwise_concordance_pattern_counter_core #(
        .MAX_POINTS(MAX_PTS),
        .MAX_DIMS  (MAX_DIM)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_point_index  (i_point_index),
        .i_dim_index    (i_dim_index),
        .i_coord_value  (i_coord_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pattern_index(o_pattern_index),
        .o_pattern_count(o_pattern_count),
        .o_is_last      (o_is_last),
        .o_is_done_ack  (o_is_done_ack)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pairwise_concordance_pattern_counter_core_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int active_points();
        return (int'(cfg_points) > MAX_PTS) ? MAX_PTS : int'(cfg_points);
    endfunction

    // zero dims behaves as one, oversize saturates
    function automatic int active_dims();
        if (cfg_dims == '0)
            return 1;
        return (int'(cfg_dims) > MAX_DIM) ? MAX_DIM : int'(cfg_dims);
    endfunction

    // saturating count bump
    function automatic void count_partner(input int p, input logic [PAT_IDX_W-1:0] s);
        if (tally[p][s] != COUNT_MAX)
            tally[p][s] = tally[p][s] + 1'b1;
    endfunction

    // clear all counts, then visit every pair i < j
    function automatic void run_pair_sweep();
        int n;
        int d;
        bit below;
        bit hit;
        logic [PAT_IDX_W-1:0] pat;
        n = active_points();
        d = active_dims();
        for (int p = 0; p < MAX_PTS; p++)
            for (int s = 0; s < PAT_SLOTS; s++)
                tally[p][s] = '0;
        for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                // a tie in the reference coordinate counts as not below
                below = coord_mem[i][0] < coord_mem[j][0];
                pat = '0;
                for (int k = 1; k < d; k++) begin
                    hit = below ? (coord_mem[i][k] < coord_mem[j][k])
                                : (coord_mem[i][k] > coord_mem[j][k]);
                    if (hit)
                        pat[k-1] = 1'b1;
                end
                count_partner(i, pat);
                count_partner(j, pat);
            end
        end
    endfunction

    // update the model for one accepted request and queue its results
    function automatic void apply_request(input logic [OP_W-1:0] op,
                                          input logic [PT_IDX_W-1:0] pt,
                                          input logic [DIM_IDX_W-1:0] dim,
                                          input logic signed [COORD_W-1:0] val);
        t_count_result rec;
        int m;
        case (op)
            OP_LOAD: begin
                // out-of-range coordinate slots are dropped
                if (int'(pt) < MAX_PTS && int'(dim) < MAX_DIM) begin
                    coord_mem[pt][dim] = val;
                    coord_set[pt][dim] = 1'b1;
                    loads_taken++;
                end
            end
            OP_SWEEP: begin
                run_pair_sweep();
                rec.pattern_index = '0;
                rec.pattern_count = '0;
                rec.is_last       = 1'b1;
                rec.is_done_ack   = 1'b1;
                expected_q.push_back(rec);
                sweeps_taken++;
            end
            OP_READ: begin
                m = 1 << (active_dims() - 1);
                for (int s = 0; s < m; s++) begin
                    rec.pattern_index = PAT_IDX_W'(s);
                    rec.pattern_count = (int'(pt) < MAX_PTS) ? tally[pt][s] : '0;
                    rec.is_last       = (s == m - 1);
                    rec.is_done_ack   = 1'b0;
                    expected_q.push_back(rec);
                end
                reads_taken++;
            end
            default: begin
                // unused code, nothing happens
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // one request: optional gap, then hold valid until taken
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [PT_IDX_W-1:0] pt,
                                input logic [DIM_IDX_W-1:0] dim,
                                input logic signed [COORD_W-1:0] val);
        int gap;
        gap = send_gaps ? int'($urandom_range(0, GAP_MAX)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_point_index <= pt;
        i_dim_index   <= dim;
        i_coord_value <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        apply_request(op, pt, dim, val);
    endtask

    task automatic read_point(input logic [PT_IDX_W-1:0] pt);
        send_request(OP_READ, pt, DIM_IDX_W'($urandom), $urandom);
    endtask

    // mostly low points that take part in sweeps, now and then any point
    function automatic logic [PT_IDX_W-1:0] pick_point();
        if ($urandom_range(0, 4) == 0)
            return PT_IDX_W'($urandom_range(0, MAX_PTS - 1));
        return PT_IDX_W'($urandom_range(0, 31));
    endfunction

    // tie-prone small values, the extremes, or anything
    function automatic logic signed [COORD_W-1:0] draw_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = COORD_W'(int'($urandom_range(0, 4)) - 2);
            1:       v = ($urandom_range(0, 1) == 0) ? COORD_MAXV : COORD_MINV;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // wait for all results, then let a load still in flight land
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_POINTS: cfg_points = POINTS_W'(value);
            REG_DIMS:   cfg_dims   = DIMS_W'(value);
            default:    ;
        endcase
    endtask

    // load any coordinate the sweep would touch that was never written
    task automatic sweep_with_fill();
        for (int p = 0; p < active_points(); p++)
            for (int k = 0; k < active_dims(); k++)
                if (!coord_set[p][k])
                    send_request(OP_LOAD, PT_IDX_W'(p), DIM_IDX_W'(k), draw_coord());
        send_request(OP_SWEEP, PT_IDX_W'($urandom), DIM_IDX_W'($urandom), $urandom);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // random stall per result, plus the long hold-off when asked
    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (holds_taken != holds_asked) begin
                holds_taken++;
                stall = HOLD_OFF_CYCLES;
            end else if (sink_stalls) begin
                stall = int'($urandom_range(0, GAP_MAX));
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_count_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            results_checked++;
            if (expected_q.size() == 0) begin
                $error("result with none expected: pattern_index %0d pattern_count %0d",
                       o_pattern_index, o_pattern_count);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_pattern_index !== want.pattern_index) begin
                    $error("pattern_index: expected %0d, got %0d",
                           want.pattern_index, o_pattern_index);
                    fail_count++;
                end
                if (o_pattern_count !== want.pattern_count) begin
                    $error("pattern_count: expected %0d, got %0d",
                           want.pattern_count, o_pattern_count);
                    fail_count++;
                end
                if (o_is_last !== want.is_last) begin
                    $error("is_last: expected %0d, got %0d", want.is_last, o_is_last);
                    fail_count++;
                end
                if (o_is_done_ack !== want.is_done_ack) begin
                    $error("is_done_ack: expected %0d, got %0d",
                           want.is_done_ack, o_is_done_ack);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values: two points, two coordinates, opposite extremes
    task automatic test_reset_defaults();
        send_request(OP_LOAD, 10'd0, 3'd0, COORD_MINV);
        send_request(OP_LOAD, 10'd0, 3'd1, COORD_MAXV);
        send_request(OP_LOAD, 10'd1, 3'd0, COORD_MAXV);
        send_request(OP_LOAD, 10'd1, 3'd1, COORD_MINV);
        sweep_with_fill();
        read_point(10'd0);
        read_point(10'd1);
    endtask

    // ties, ignored requests and the highest point index
    task automatic test_coordinate_corners();
        write_reg(REG_DIMS, 3);
        write_reg(REG_POINTS, 3);
        send_request(OP_LOAD, 10'd0, 3'd2, '0);
        send_request(OP_LOAD, 10'd1, 3'd2, -32'sd1);
        // reference coordinate tied with point 1
        send_request(OP_LOAD, 10'd2, 3'd0, COORD_MAXV);
        send_request(OP_LOAD, 10'd2, 3'd1, '0);
        // tied with point 0 in the last coordinate
        send_request(OP_LOAD, 10'd2, 3'd2, '0);
        // a dimension past the last must not spill into the next point
        send_request(OP_LOAD, 10'd0, DIM_BEYOND, -32'sd5);
        send_request(OP_UNUSED, 10'h3ff, 3'd7, 32'hffff_ffff);
        send_request(OP_LOAD, 10'h3ff, 3'd6, 32'sh5a5a_a5a5);
        sweep_with_fill();
        read_point(10'd0);
        read_point(10'd1);
        read_point(10'd2);
        read_point(10'h3ff);
    endtask

    // reads follow the current dims setting, not the one of the sweep
    task automatic test_dims_change_after_sweep();
        write_reg(REG_DIMS, 6);
        read_point(10'd1);
        write_reg(REG_DIMS, 1);
        read_point(10'd2);
    endtask

    // no pairs at all, and zero dims acting as one
    task automatic test_degenerate_sweeps();
        write_reg(REG_POINTS, 0);
        sweep_with_fill();
        read_point(10'd0);
        write_reg(REG_DIMS, 0);
        write_reg(REG_POINTS, 3);
        sweep_with_fill();
        read_point(10'd2);
    endtask

    // point counts at and above the table size, with reads only
    task automatic test_large_point_settings();
        write_reg(REG_POINTS, 2047);
        read_point(10'd0);
        write_reg(REG_POINTS, 1024);
        write_reg(REG_DIMS, 7);
        read_point(10'h3ff);
    endtask

    // rounds of new settings, loads with noise, a sweep and reads
    task automatic test_random_rounds();
        int start_count;
        int round;
        int pick;
        start_count = loads_taken + sweeps_taken + reads_taken;
        round = 0;
        while (loads_taken + sweeps_taken + reads_taken - start_count < RANDOM_ITEMS
               && round < MAX_ROUNDS) begin
            write_reg(REG_DIMS, $urandom_range(0, 7));
            write_reg(REG_POINTS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                              : $urandom_range(2, 32));
            send_gaps   = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(14, 28)) begin
                pick = int'($urandom_range(0, 11));
                if (pick == 0)
                    send_request(OP_UNUSED, PT_IDX_W'($urandom), DIM_IDX_W'($urandom),
                                 $urandom);
                else if (pick == 1)
                    send_request(OP_LOAD, pick_point(), DIM_BEYOND, $urandom);
                else
                    send_request(OP_LOAD, pick_point(),
                                 DIM_IDX_W'($urandom_range(0, MAX_DIM - 1)), draw_coord());
            end
            sweep_with_fill();
            repeat ($urandom_range(6, 12)) read_point(pick_point());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_DIMS, $urandom_range(0, 7));
                repeat (2) read_point(pick_point());
            end
            round++;
        end
    endtask

    // long result hold-off while full-size reads keep coming
    task automatic test_output_backpressure();
        write_reg(REG_DIMS, 7);
        send_gaps   = 1'b0;
        sink_stalls = 1'b1;
        holds_asked++;
        repeat (8) read_point(pick_point());
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_coordinate_corners();
        test_dims_change_after_sweep();
        test_degenerate_sweeps();
        test_large_point_settings();
        test_random_rounds();
        test_output_backpressure();
        wait_idle();
        $display("summary: %0d requests (%0d loads, %0d sweeps, %0d reads), %0d results compared",
                 loads_taken + sweeps_taken + reads_taken, loads_taken, sweeps_taken,
                 reads_taken, results_checked);
        $display("summary: point counts 0 to 2047, dims 0 to 7, %0d cycles", cycle_count);
        if (fail_count == 0)
            $display("pairwise_concordance_pattern_counter_core_tb: clean");
        else
            $display("pairwise_concordance_pattern_counter_core_tb: errors");
        $finish;
    end

endmodule
